// ----- sv/bpa_pkg.sv -----
// bpa_pkg: shared types and constants of the buddy page allocator
// command and response words, status codes, map port control
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	localparam int ORDERS_DEF     = 6;
	localparam int PAGE_SHIFT_DEF = 12;
	localparam int ADDR_W         = 48;
	localparam int ORD_W          = 3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_MEM    = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_BAD_ORDER = 2'd3
	} status_t;

	typedef struct packed {
		logic              action;
		logic [ORD_W-1:0]  order;
		logic [ADDR_W-1:0] block_address;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		status_t           status;
	} rsp_t;

	// one read port and one write port of a map memory
	typedef struct packed {
		logic             rd_en;
		logic [ORD_W-1:0] rd_idx;
		logic             wr_en;
		logic [ORD_W-1:0] wr_idx;
	} map_ctl_t;

endpackage

`default_nettype wire

// ----- sv/buddy_page_allocator_top.sv -----
// buddy_page_allocator_top: buddy page allocator sequencer and result register
// walks the per-order free and used bitmaps held in bpa_maps
// depends on bpa_pkg and bpa_maps
//
//   port group        dir  width            role
//   start / busy      in   1 / out 1        command word taken when start && !busy
//   cmd               in   cmd_t (52)       action, order, block_address
//   done / result     out  1 / rsp_t (50)   result word, valid for one cycle
//   cfg_wr_en/data    in   1 / 48           region_base write, no read-back
//
// one command in flight; busy is high from the cycle after acceptance through done
// allocate: probe free rows upward from the requested order, split back down, mark used
// free: probe used rows upward from order 0, then merge with free buddies upward
// no memory or not allocated: every order is probed; bad order or bad address: straight
// from decode to done; the one-row-per-cycle map read port sets the pace
// after reset all map rows read as their reset pattern at once; no sweep
// the result cannot be stalled: done is a one-cycle strobe
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator_top #(
	parameter int ORDERS     = bpa_pkg::ORDERS_DEF,
	parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire bpa_pkg::cmd_t              cmd,
	output logic                            done,
	output bpa_pkg::rsp_t                   result,
	input  wire logic                       cfg_wr_en,
	input  wire logic [bpa_pkg::ADDR_W-1:0] cfg_wr_data
);

	localparam int PAGES  = 1 << ORDERS;
	localparam int IDX_W  = $clog2(ORDERS);
	localparam int ADDR_W = bpa_pkg::ADDR_W;
	localparam int ORD_W  = bpa_pkg::ORD_W;

	// sequencer states, one-hot
	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_DECODE  = 13'b0000000000010,
		S_A_RD    = 13'b0000000000100,  // probe free row for allocate
		S_A_CHK   = 13'b0000000001000,
		S_A_TOP   = 13'b0000000010000,  // take lowest block of the found order
		S_A_SPLIT = 13'b0000000100000,  // leave upper halves free going down
		S_A_URD   = 13'b0000001000000,
		S_A_UWR   = 13'b0000010000000,  // mark the block allocated
		S_F_RD    = 13'b0000100000000,  // probe used row for free
		S_F_CHK   = 13'b0001000000000,
		S_F_FRD   = 13'b0010000000000,
		S_F_MERGE = 13'b0100000000000,  // merge with buddy while it is free
		S_DONE    = 13'b1000000000000
	} state_t;

	state_t                 state_q;
	logic [ADDR_W-1:0]      base_q;
	bpa_pkg::cmd_t          cmd_q;
	bpa_pkg::rsp_t          rsp_q;
	logic [IDX_W-1:0]       idx_q;   // order being worked on
	logic [ORDERS-1:0]      page_q;  // page of the block being worked on
	logic [PAGES-1:0]       word_q;

	bpa_pkg::map_ctl_t      free_ctl;
	bpa_pkg::map_ctl_t      used_ctl;
	logic [PAGES-1:0]       free_wdata;
	logic [PAGES-1:0]       used_wdata;
	logic [PAGES-1:0]       free_rdata;
	logic [PAGES-1:0]       used_rdata;

	logic [IDX_W-1:0]       ord_idx;
	logic                   ord_bad;
	logic [ADDR_W-1:0]      offset;
	logic                   addr_bad;
	logic [ORDERS-1:0]      low_p;
	logic                   last;
	logic [ORDERS-1:0]      order_bit;
	logic [ORDERS-1:0]      buddy;
	logic [ORDERS-1:0]      split_pg;
	logic [PAGES-1:0]       bit_p;
	logic [PAGES-1:0]       bit_b;
	logic [PAGES-1:0]       merge_word;
	logic                   can_merge;
	logic                   used_hit;
	logic [ADDR_W-1:0]      alloc_addr;

	// lowest set bit, priority encoder over one map row
	function automatic logic [ORDERS-1:0] lowest(input logic [PAGES-1:0] w);
		logic [ORDERS-1:0] r;
		r = '0;
		for (int i = PAGES - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = ORDERS'(i);
			end
		end
		return r;
	endfunction

	bpa_maps #(
		.ORDERS(ORDERS)
	) u_maps (
		.clk       (clk),
		.arst_n    (arst_n),
		.free_ctl  (free_ctl),
		.free_wdata(free_wdata),
		.free_rdata(free_rdata),
		.used_ctl  (used_ctl),
		.used_wdata(used_wdata),
		.used_rdata(used_rdata)
	);

	// decode of the latched command
	assign ord_idx  = cmd_q.order[IDX_W-1:0];
	assign ord_bad  = cmd_q.order >= ORD_W'(ORDERS);
	// byte offset into the region, wraps modulo 2^48
	assign offset   = cmd_q.block_address - base_q;
	assign addr_bad = (|offset[PAGE_SHIFT-1:0]) || (|offset[ADDR_W-1:PAGE_SHIFT+ORDERS]);

	// per-order bit arithmetic
	assign low_p      = lowest(free_rdata);
	assign last       = idx_q == IDX_W'(ORDERS - 1);
	assign order_bit  = ORDERS'(1) << idx_q;
	assign buddy      = page_q ^ order_bit;
	// upper half of the split block; stays inside the region
	assign split_pg   = page_q + order_bit;
	assign bit_p      = PAGES'(1) << page_q;
	assign bit_b      = PAGES'(1) << buddy;
	assign merge_word = free_rdata | bit_p;
	// the top order never merges further
	assign can_merge  = !last && merge_word[buddy];
	assign used_hit   = used_rdata[page_q];
	assign alloc_addr = base_q + (ADDR_W'(page_q) << PAGE_SHIFT);

	// map port control
	always_comb begin
		free_ctl   = '0;
		used_ctl   = '0;
		free_wdata = '0;
		used_wdata = '0;
		case (state_q)
			S_A_RD: begin
				free_ctl.rd_en  = 1'b1;
				free_ctl.rd_idx = ORD_W'(idx_q);
			end
			S_A_TOP: begin
				free_ctl.wr_en  = 1'b1;
				free_ctl.wr_idx = ORD_W'(idx_q);
				free_wdata      = word_q & ~bit_p;
			end
			S_A_SPLIT: begin
				// these rows were empty, so only the upper half remains
				free_ctl.wr_en  = 1'b1;
				free_ctl.wr_idx = ORD_W'(idx_q);
				free_wdata      = PAGES'(1) << split_pg;
			end
			S_A_URD: begin
				used_ctl.rd_en  = 1'b1;
				used_ctl.rd_idx = ORD_W'(ord_idx);
			end
			S_A_UWR: begin
				used_ctl.wr_en  = 1'b1;
				used_ctl.wr_idx = ORD_W'(ord_idx);
				used_wdata      = used_rdata | bit_p;
			end
			S_F_RD: begin
				used_ctl.rd_en  = 1'b1;
				used_ctl.rd_idx = ORD_W'(idx_q);
			end
			S_F_CHK: begin
				used_ctl.wr_en  = used_hit;
				used_ctl.wr_idx = ORD_W'(idx_q);
				used_wdata      = used_rdata & ~bit_p;
			end
			S_F_FRD: begin
				free_ctl.rd_en  = 1'b1;
				free_ctl.rd_idx = ORD_W'(idx_q);
			end
			S_F_MERGE: begin
				// write this order and fetch the next one in the same cycle
				free_ctl.wr_en  = 1'b1;
				free_ctl.wr_idx = ORD_W'(idx_q);
				free_wdata      = can_merge ? (merge_word & ~(bit_p | bit_b)) : merge_word;
				free_ctl.rd_en  = can_merge;
				free_ctl.rd_idx = ORD_W'(idx_q) + ORD_W'(1);
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (cmd_q.action == bpa_pkg::ACT_ALLOC) begin
						state_q <= ord_bad ? S_DONE : S_A_RD;
					end else begin
						state_q <= addr_bad ? S_DONE : S_F_RD;
					end
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					if (free_rdata != '0) begin
						state_q <= S_A_TOP;
					end else if (last) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_A_TOP: state_q <= (idx_q == ord_idx) ? S_A_URD : S_A_SPLIT;
				S_A_SPLIT: begin
					if (idx_q == ord_idx) begin
						state_q <= S_A_URD;
					end
				end
				S_A_URD: state_q <= S_A_UWR;
				S_A_UWR: state_q <= S_DONE;
				S_F_RD: state_q <= S_F_CHK;
				S_F_CHK: begin
					if (used_hit) begin
						state_q <= S_F_FRD;
					end else if (last) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_F_FRD: state_q <= S_F_MERGE;
				S_F_MERGE: begin
					if (!can_merge) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
				end
			end
			S_DECODE: begin
				rsp_q.result_address <= '0;
				if (cmd_q.action == bpa_pkg::ACT_ALLOC) begin
					idx_q        <= ord_idx;
					rsp_q.status <= ord_bad ? bpa_pkg::ST_BAD_ORDER : bpa_pkg::ST_OK;
				end else begin
					idx_q        <= '0;
					page_q       <= offset[PAGE_SHIFT+ORDERS-1:PAGE_SHIFT];
					rsp_q.status <= addr_bad ? bpa_pkg::ST_NOT_ALLOC : bpa_pkg::ST_OK;
				end
			end
			S_A_CHK: begin
				if (free_rdata != '0) begin
					page_q <= low_p;
					word_q <= free_rdata;
				end else if (last) begin
					rsp_q.status <= bpa_pkg::ST_NO_MEM;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			S_A_TOP, S_A_SPLIT: begin
				if (idx_q != ord_idx) begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			S_A_UWR: begin
				rsp_q.result_address <= alloc_addr;
			end
			S_F_CHK: begin
				if (!used_hit) begin
					if (last) begin
						rsp_q.status <= bpa_pkg::ST_NOT_ALLOC;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
			end
			S_F_MERGE: begin
				if (can_merge) begin
					page_q <= page_q & ~order_bit;
					idx_q  <= idx_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = state_q != S_IDLE;
	assign done   = state_q == S_DONE;
	assign result = rsp_q;

endmodule

`default_nettype wire

// ----- sv/bpa_maps.sv -----
// bpa_maps: free and used bitmaps, one row per order, synchronous read
// rows carry a valid bit so an unwritten row reads as its reset pattern
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpa_maps #(
	parameter int ORDERS = bpa_pkg::ORDERS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bpa_pkg::map_ctl_t      free_ctl,
	input  wire logic [(1<<ORDERS)-1:0] free_wdata,
	output logic      [(1<<ORDERS)-1:0] free_rdata,
	input  wire bpa_pkg::map_ctl_t      used_ctl,
	input  wire logic [(1<<ORDERS)-1:0] used_wdata,
	output logic      [(1<<ORDERS)-1:0] used_rdata
);

	localparam int PAGES = 1 << ORDERS;
	localparam int IDX_W = $clog2(ORDERS);

	logic [PAGES-1:0] free_mem [ORDERS];
	logic [PAGES-1:0] used_mem [ORDERS];
	logic [ORDERS-1:0] free_vld_q;
	logic [ORDERS-1:0] used_vld_q;

	logic [PAGES-1:0] free_rd_s1;
	logic [PAGES-1:0] used_rd_s1;
	logic             free_rvld_s1;
	logic             used_rvld_s1;
	logic [IDX_W-1:0] free_ridx_s1;
	logic [PAGES-1:0] free_reset_val;

	// memory arrays, no reset
	always_ff @(posedge clk) begin
		if (free_ctl.wr_en) begin
			free_mem[free_ctl.wr_idx[IDX_W-1:0]] <= free_wdata;
		end
		if (used_ctl.wr_en) begin
			used_mem[used_ctl.wr_idx[IDX_W-1:0]] <= used_wdata;
		end
		if (free_ctl.rd_en) begin
			free_rd_s1   <= free_mem[free_ctl.rd_idx[IDX_W-1:0]];
			free_ridx_s1 <= free_ctl.rd_idx[IDX_W-1:0];
		end
		if (used_ctl.rd_en) begin
			used_rd_s1 <= used_mem[used_ctl.rd_idx[IDX_W-1:0]];
		end
	end

	// row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_vld_q   <= '0;
			used_vld_q   <= '0;
			free_rvld_s1 <= 1'b0;
			used_rvld_s1 <= 1'b0;
		end else begin
			if (free_ctl.wr_en) begin
				free_vld_q[free_ctl.wr_idx[IDX_W-1:0]] <= 1'b1;
			end
			if (used_ctl.wr_en) begin
				used_vld_q[used_ctl.wr_idx[IDX_W-1:0]] <= 1'b1;
			end
			if (free_ctl.rd_en) begin
				free_rvld_s1 <= free_vld_q[free_ctl.rd_idx[IDX_W-1:0]];
			end
			if (used_ctl.rd_en) begin
				used_rvld_s1 <= used_vld_q[used_ctl.rd_idx[IDX_W-1:0]];
			end
		end
	end

	// order k starts out with a single free block at page 2^k
	assign free_reset_val = PAGES'(1) << (ORDERS'(1) << free_ridx_s1);

	assign free_rdata = free_rvld_s1 ? free_rd_s1 : free_reset_val;
	assign used_rdata = used_rvld_s1 ? used_rd_s1 : '0;

endmodule

`default_nettype wire

// ----- sv/bpa_checker.sv -----
// bpa_checker: port-level checks of the buddy page allocator
// bound to buddy_page_allocator_top; depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire bpa_pkg::cmd_t              cmd,
	input wire logic                       done,
	input wire bpa_pkg::rsp_t              result
);

	logic free_q;

	// action of the command in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= 1'b0;
		end else if (start && !busy) begin
			free_q <= cmd.action == bpa_pkg::ACT_FREE;
		end
	end

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result word only appears while a command is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result word while idle");

	// one result word per command, then ready again
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block did not return to idle after result word");

	// failures carry a zero address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != bpa_pkg::ST_OK |-> result.result_address == '0)
		else $error("nonzero address on failed command");

	// a free never returns an address
	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && free_q |-> result.result_address == '0)
		else $error("nonzero address on free command");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (.*);

`default_nettype wire

// ----- verif/buddy_page_allocator_top_test.sv -----
// buddy_page_allocator_top_test: self-checking bench for the buddy page allocator
// drives command words, mirrors the per-order free and used bitmaps, checks each result word
// depends on bpa_pkg and buddy_page_allocator_top
`timescale 1ns / 1ps

module buddy_page_allocator_top_test;

	localparam int ORDERS       = bpa_pkg::ORDERS_DEF;
	localparam int PAGE_SHIFT   = bpa_pkg::PAGE_SHIFT_DEF;
	localparam int PAGES        = 1 << ORDERS;
	localparam int ADDR_W       = bpa_pkg::ADDR_W;
	localparam int ORD_W        = bpa_pkg::ORD_W;
	// leave plenty of room after the worst command before touching the register
	localparam int SETTLE       = 40;
	localparam int PHASES       = 6;
	localparam int RANDOM_WORDS = 1380;
	localparam longint CYCLE_LIMIT = 400000;

	// one row of the directed table; typed rows carry their result, the rest use the mirror
	typedef struct {
		bpa_pkg::cmd_t c;
		bit            typed;
		bpa_pkg::rsp_t want;
	} drow_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	bpa_pkg::cmd_t     cmd = '0;
	logic              done;
	bpa_pkg::rsp_t     result;
	logic              cfg_wr_en = 1'b0;
	logic [ADDR_W-1:0] cfg_wr_data = '0;

	// mirror of the allocator: one bit per page marking a free or a used block start
	logic [PAGES-1:0]  free_rows [ORDERS];
	logic [PAGES-1:0]  used_rows [ORDERS];
	logic [ADDR_W-1:0] base_mirror;

	bpa_pkg::rsp_t awaited_rsp[$];   // result words still owed by the block, oldest first
	int            live_pages[$];    // start pages of blocks the mirror holds as allocated
	int unsigned   err_count = 0;
	longint        cycle_count = 0;

	buddy_page_allocator_top #(
		.ORDERS     (ORDERS),
		.PAGE_SHIFT (PAGE_SHIFT)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		err_count++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	function automatic logic [ADDR_W-1:0] rand48();
		logic [ADDR_W-1:0] v;
		v = ADDR_W'({$urandom(), $urandom()});
		return v;
	endfunction

	// ---------------------------------------------------------------
	// mirror of the allocator
	// ---------------------------------------------------------------

	// state after reset: order k holds one free block at page 2^k, page 0 stays reserved
	task automatic mirror_reset();
		for (int k = 0; k < ORDERS; k++) begin
			free_rows[k] = '0;
			free_rows[k][1 << k] = 1'b1;
			used_rows[k] = '0;
		end
		base_mirror = '0;
	endtask

	function automatic int lowest_page(input logic [PAGES-1:0] row);
		for (int i = 0; i < PAGES; i++)
			if (row[i])
				return i;
		return PAGES - 1;
	endfunction

	// allocate: find the nearest order with a free block, split down, take the lowest start
	task automatic take_block(input int ord, output bpa_pkg::status_t st,
			output logic [ADDR_W-1:0] addr);
		int j;
		int p;
		logic [ADDR_W-1:0] span;
		addr = '0;
		j = ord;
		while (j < ORDERS && free_rows[j] == '0)
			j++;
		if (j >= ORDERS) begin
			st = bpa_pkg::ST_NO_MEM;
			return;
		end
		// each split leaves both halves free one order down; the lower one splits again
		while (j > ord) begin
			p = lowest_page(free_rows[j]);
			free_rows[j][p] = 1'b0;
			j--;
			free_rows[j][p] = 1'b1;
			free_rows[j][p + (1 << j)] = 1'b1;
		end
		p = lowest_page(free_rows[ord]);
		free_rows[ord][p] = 1'b0;
		used_rows[ord][p] = 1'b1;
		span = ADDR_W'(p);
		span = span << PAGE_SHIFT;
		addr = base_mirror + span;   // wraps modulo 2^48
		st = bpa_pkg::ST_OK;
	endtask

	// free: look the page up among used starts, then merge with free buddies upward
	task automatic return_block(input logic [ADDR_W-1:0] a, output bpa_pkg::status_t st);
		logic [ADDR_W-1:0] offset;
		int k;
		int p;
		int b;
		st = bpa_pkg::ST_NOT_ALLOC;
		offset = a - base_mirror;   // an address below the base wraps beyond the region
		if (offset[PAGE_SHIFT-1:0] != '0)
			return;
		if ((offset >> PAGE_SHIFT) >= PAGES)
			return;
		p = int'(offset[PAGE_SHIFT +: ORDERS]);
		k = 0;
		while (k < ORDERS && !used_rows[k][p])
			k++;
		if (k >= ORDERS)
			return;
		used_rows[k][p] = 1'b0;
		free_rows[k][p] = 1'b1;
		// top order never merges
		while (k + 1 < ORDERS) begin
			b = p ^ (1 << k);
			if (!free_rows[k][b])
				break;
			free_rows[k][p] = 1'b0;
			free_rows[k][b] = 1'b0;
			p = p & ~(1 << k);
			k++;
			free_rows[k][p] = 1'b1;
		end
		st = bpa_pkg::ST_OK;
	endtask

	// result word for one command; updates the mirror
	task automatic predict_word(input bpa_pkg::cmd_t c, output bpa_pkg::rsp_t r);
		bpa_pkg::status_t st;
		logic [ADDR_W-1:0] a;
		a = '0;
		if (c.action == bpa_pkg::ACT_ALLOC) begin
			if (c.order >= ORDERS)
				st = bpa_pkg::ST_BAD_ORDER;
			else
				take_block(int'(c.order), st, a);
		end else begin
			return_block(c.block_address, st);   // order field ignored on free
		end
		if (st != bpa_pkg::ST_OK)
			a = '0;
		r.result_address = a;
		r.status = st;
	endtask

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// present one command word after a gap; start stays high until start && !busy at an edge
	task automatic issue_word(input bpa_pkg::cmd_t c, input int gap, input bit typed,
			input bpa_pkg::rsp_t typed_rsp);
		bpa_pkg::rsp_t r;
		logic [ADDR_W-1:0] offset;
		int idx;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		// word taken at this edge
		predict_word(c, r);
		awaited_rsp.push_back(typed ? typed_rsp : r);
		// keep the list of live blocks in step so the random part can free them
		if (r.status == bpa_pkg::ST_OK) begin
			if (c.action == bpa_pkg::ACT_ALLOC) begin
				offset = r.result_address - base_mirror;
				live_pages.push_back(int'(offset[PAGE_SHIFT +: ORDERS]));
			end else begin
				offset = c.block_address - base_mirror;
				idx = -1;
				foreach (live_pages[i])
					if (live_pages[i] == int'(offset[PAGE_SHIFT +: ORDERS]))
						idx = i;
				if (idx >= 0)
					live_pages.delete(idx);
			end
		end
	endtask

	// stop sending, wait for every owed word, then let the block go quiet
	task automatic drain();
		start <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// region_base write, only while idle
	task automatic write_base(input logic [ADDR_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		base_mirror = v;
	endtask

	function automatic drow_t step_row(input logic act, input int ord, input logic [ADDR_W-1:0] a,
			input bit typed, input bpa_pkg::status_t st, input logic [ADDR_W-1:0] ra);
		drow_t d;
		d.c.action = act;
		d.c.order = ORD_W'(ord);
		d.c.block_address = a;
		d.typed = typed;
		d.want.result_address = ra;
		d.want.status = st;
		return d;
	endfunction

	// random command: mostly allocations and frees of live blocks, with some bad orders and bad frees mixed in
	function automatic bpa_pkg::cmd_t random_word();
		bpa_pkg::cmd_t c;
		int pct;
		logic [ADDR_W-1:0] span;
		c.action = bpa_pkg::ACT_ALLOC;
		c.order = ORD_W'($urandom_range(0, 7));
		c.block_address = rand48();
		// lean toward allocating when few blocks are out, toward freeing when many are
		pct = (live_pages.size() < 6) ? 70 : ((live_pages.size() > 20) ? 30 : 50);
		if (live_pages.size() == 0 || $urandom_range(0, 99) < pct) begin
			// low orders more likely; one in twenty keeps the full 0..7 range
			if ($urandom_range(0, 19) != 0)
				c.order = ORD_W'($urandom_range(0, $urandom_range(0, ORDERS - 1)));
		end else begin
			c.action = bpa_pkg::ACT_FREE;
			span = ADDR_W'(live_pages[$urandom_range(0, live_pages.size() - 1)]);
			span = span << PAGE_SHIFT;
			c.block_address = base_mirror + span;
			case ($urandom_range(0, 19))
				0: begin
					// not on a page boundary
					c.block_address = c.block_address
						+ ADDR_W'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
				end
				1: begin
					// beyond the region
					span = rand48();
					span[PAGE_SHIFT-1:0] = '0;
					if (span < (PAGES << PAGE_SHIFT))
						span[ADDR_W-1] = 1'b1;
					c.block_address = base_mirror + span;
				end
				2: begin
					// just below the base
					span = ADDR_W'($urandom_range(1, PAGES));
					span = span << PAGE_SHIFT;
					c.block_address = base_mirror - span;
				end
				3: c.block_address = rand48();
				4: begin
					// any page start, allocated or not
					span = ADDR_W'($urandom_range(0, PAGES - 1));
					span = span << PAGE_SHIFT;
					c.block_address = base_mirror + span;
				end
				default: ;
			endcase
		end
		return c;
	endfunction

	// ---------------------------------------------------------------
	// result checker: done is a one-cycle strobe, compare against the oldest owed word
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		bpa_pkg::rsp_t want;
		if (done === 1'b1) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch("word with nothing awaited", result.result_address, '0);
			end else begin
				want = awaited_rsp.pop_front();
				if (result.result_address !== want.result_address)
					report_mismatch("result_address", result.result_address, want.result_address);
				if (result.status !== want.status)
					report_mismatch("status", ADDR_W'(result.status), ADDR_W'(want.status));
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		drow_t plan[$];
		logic [ADDR_W-1:0] bases[PHASES];
		int gap;
		int burst_left;
		burst_left = 0;
		mirror_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base('0);

		// directed part at base 0; starts free: p1 o0, p2 o1, p4 o2, p8 o3, p16 o4, p32 o5
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 6, '0, 1, bpa_pkg::ST_BAD_ORDER, '0));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 7, 48'hFFFF_FFFF_FFFF, 1,
			bpa_pkg::ST_BAD_ORDER, '0));
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, '0, 1,
			bpa_pkg::ST_NOT_ALLOC, '0));                                            // reserved page
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h1001, 1,
			bpa_pkg::ST_NOT_ALLOC, '0));                                            // off boundary
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h4_0000, 1,
			bpa_pkg::ST_NOT_ALLOC, '0));                                            // past the end
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 7, 48'hFFFF_FFFF_F000, 1,
			bpa_pkg::ST_NOT_ALLOC, '0));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 0, '0, 1, bpa_pkg::ST_OK, 48'h1000));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 0, '0, 0, bpa_pkg::ST_OK, '0)); // splits order 1
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 5, '0, 1, bpa_pkg::ST_OK, 48'h2_0000));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 5, '0, 1, bpa_pkg::ST_NO_MEM, '0));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 4, '0, 1, bpa_pkg::ST_OK, 48'h1_0000));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 3, '0, 1, bpa_pkg::ST_OK, 48'h8000));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 2, '0, 1, bpa_pkg::ST_OK, 48'h4000));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 1, '0, 1,
			bpa_pkg::ST_NO_MEM, '0));                                               // nothing to split
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 0, '0, 0, bpa_pkg::ST_OK, '0));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 0, '0, 1, bpa_pkg::ST_NO_MEM, '0));
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h1000, 1, bpa_pkg::ST_OK, '0));
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h1000, 1,
			bpa_pkg::ST_NOT_ALLOC, '0));                                            // double free
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h3000, 0, bpa_pkg::ST_OK, '0));
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h2000, 0,
			bpa_pkg::ST_OK, '0));                                                   // merges to order 1
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h2_1000, 1,
			bpa_pkg::ST_NOT_ALLOC, '0));                                            // inside a block
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h2_0000, 1,
			bpa_pkg::ST_OK, '0));                                                   // top order
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 0, 48'h1_0000, 1, bpa_pkg::ST_OK, '0));
		plan.push_back(step_row(bpa_pkg::ACT_ALLOC, 1, 48'hA5A5_5A5A_0F0F, 0, bpa_pkg::ST_OK, '0));
		plan.push_back(step_row(bpa_pkg::ACT_FREE, 7, 48'h8000, 1,
			bpa_pkg::ST_OK, '0));                                                   // order ignored
		foreach (plan[i])
			issue_word(plan[i].c, $urandom_range(0, 8), plan[i].typed, plan[i].want);
		drain();

		// random phases, each under its own region base; live blocks carry across
		bases[0] = 48'hFFFF_FFFF_FFFF;   // all ones, unaligned, addresses wrap
		bases[1] = 48'hFFFF_FFFC_0000;   // highest aligned base
		bases[2] = rand48();
		bases[2][ORDERS+PAGE_SHIFT-1:0] = '0;
		bases[3] = rand48();             // most likely unaligned
		bases[4] = 48'h0000_0004_0000;
		bases[5] = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_base(bases[ph]);
			for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
				// random gaps, with an occasional back-to-back burst
				if (burst_left > 0) begin
					gap = 0;
					burst_left--;
				end else begin
					gap = $urandom_range(0, 8);
					if ($urandom_range(0, 24) == 0)
						burst_left = $urandom_range(10, 40);
				end
				issue_word(random_word(), gap, 1'b0, '0);
			end
			drain();
		end

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
